/* sv/ic3_pkg.sv */
// Shared types and constants of the 3x3 image convolution block.
package ic3_pkg;

   // Fixed field widths of the streams.
   localparam int SAMPLE_BITS    = 8;
   localparam int ROW_BITS       = 10;
   localparam int COL_BITS       = 10;
   localparam int CH_BITS        = 2;
   localparam int HEIGHT_LIMIT   = 1024;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_LOW      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_MID      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_HIGH     = 3'd5;

   // Result queue geometry.
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_BITS  = 3;
   localparam int FIFO_CNT_BITS  = 4;

   // Control of one tap cell: shift a channel in, and pick a channel to multiply.
   typedef struct packed {
      logic               shift;
      logic [CH_BITS-1:0] shift_ch;
      logic [CH_BITS-1:0] prod_ch;
   } cell_ctl_type;

   // One queue entry holds every word caused by one sample.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] value0;
      logic [ROW_BITS-1:0]    row0;
      logic [COL_BITS-1:0]    col0;
      logic [CH_BITS-1:0]     ch0;
      logic                   has1;
      logic [SAMPLE_BITS-1:0] value1;
      logic [ROW_BITS-1:0]    row1;
      logic [COL_BITS-1:0]    col1;
      logic [CH_BITS-1:0]     ch1;
   } result_entry_type;

   typedef struct packed {
      logic                     full;
      logic [FIFO_CNT_BITS-1:0] count;
   } queue_status_type;

endpackage

/* sv/image_convolution_3x3_core.sv */
// Top level of the streaming 3x3 image convolution with pass-through border.
//
// The block takes one channel-interleaved 8-bit sample per clock while req_ready is high
// and returns, for each sample past the first row, the result for the pixel one row up
// and one column left (the border copied, the interior convolved with the flipped kernel,
// rounded half to even and saturated), followed on the last row by the sample itself.
// A first-row sample makes no word but in a one-row image. Words leave through an
// eight-entry result queue that lets the input run on while the output stalls. On the
// last row each sample makes two words, so there the output port sets the pace. The two
// line stores are single-write memories read in the accept cycle, and the window is three
// rows of three tap cells that shift per accepted sample and feed registered row sums.
module image_convolution_3x3_core import ic3_pkg::*; #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_CHANNELS = 4,
   parameter int COEF_BITS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_pixel_value,
   output logic [ROW_BITS-1:0]       rsp_out_row,
   output logic [COL_BITS-1:0]       rsp_out_column,
   output logic [CH_BITS-1:0]        rsp_out_channel,
   output logic                      rsp_last,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int CB          = (COEF_BITS < 16) ? COEF_BITS : 16;
   localparam int PW          = CB + SAMPLE_BITS + 1;
   localparam int RW          = PW + 2;
   localparam int SW          = PW + 4;
   localparam int QW          = SW - 7;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [ROW_BITS-1:0]    row;
      logic [COL_BITS-1:0]    col;
      logic [CH_BITS-1:0]     ch;
      logic [ROW_BITS-1:0]    row0;
      logic [COL_BITS-1:0]    col0;
      logic                   has0;
      logic                   has1;
      logic                   at_edge;
      logic                   conv;
      logic [SAMPLE_BITS-1:0] edge_value;
   } stage_info_type;

   // Configuration registers.
   logic [10:0] width_ff;
   logic [10:0] height_ff;
   logic [2:0]  chan_count_ff;
   logic [63:0] coef_low_ff;
   logic [63:0] coef_mid_ff;
   logic [15:0] coef_high_ff;
   logic        geometry_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 11'd640;
         height_ff     <= 11'd480;
         chan_count_ff <= 3'd3;
         coef_low_ff   <= '0;
         coef_mid_ff   <= '0;
         coef_high_ff  <= 16'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff      <= csr_write_data[10:0];
            CSR_IMAGE_HEIGHT:  height_ff     <= csr_write_data[10:0];
            CSR_CHANNEL_COUNT: chan_count_ff <= csr_write_data[2:0];
            CSR_COEF_LOW:      coef_low_ff   <= csr_write_data;
            CSR_COEF_MID:      coef_mid_ff   <= csr_write_data;
            CSR_COEF_HIGH:     coef_high_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign geometry_write = csr_write_enable && ((csr_index == CSR_IMAGE_WIDTH) ||
      (csr_index == CSR_IMAGE_HEIGHT) || (csr_index == CSR_CHANNEL_COUNT));

   // Clamped geometry.
   logic [CW:0] w_eff;
   logic [10:0] h_eff;
   logic [2:0]  nc_eff;

   always_comb begin
      if (width_ff == '0) w_eff = (CW+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
      else w_eff = (CW+1)'(width_ff);
      if (height_ff == '0) h_eff = 11'd1;
      else if (32'(height_ff) > HEIGHT_LIMIT) h_eff = 11'(HEIGHT_LIMIT);
      else h_eff = height_ff;
      if (chan_count_ff == '0) nc_eff = 3'd1;
      else if (32'(chan_count_ff) > MAX_CHANNELS) nc_eff = 3'(MAX_CHANNELS);
      else nc_eff = chan_count_ff;
   end

   // Raster position counters.
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [CH_BITS-1:0]  ch_ff, ch_in;
   logic                accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      ch_in  = ch_ff;
      if (accept) begin
         if (({1'b0, ch_ff} + 3'd1) >= nc_eff) begin
            ch_in = '0;
            if (((CW+1)'(col_ff) + (CW+1)'(1)) >= w_eff) begin
               col_in = '0;
               row_in = ((11'(row_ff) + 11'd1) >= h_eff) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            ch_in = ch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geometry_write) begin
         row_ff <= '0;
         col_ff <= '0;
         ch_ff  <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         ch_ff  <= ch_in;
      end
   end

   // Store addresses and the per-sample flags.
   logic [AW-1:0]  idx, lidx;
   stage_info_type s0_info;

   assign idx  = AW'(col_ff) * AW'(MAX_CHANNELS) + AW'(ch_ff);
   assign lidx = AW'(w_eff - (CW+1)'(1)) * AW'(MAX_CHANNELS) + AW'(ch_ff);

   always_comb begin
      s0_info.sample     = req_sample;
      s0_info.row        = row_ff;
      s0_info.col        = COL_BITS'(col_ff);
      s0_info.ch         = ch_ff;
      s0_info.row0       = row_ff - 1'b1;
      s0_info.at_edge    = (col_ff == '0);
      s0_info.col0       = (col_ff == '0) ? COL_BITS'(w_eff - (CW+1)'(1))
                                          : COL_BITS'(col_ff - 1'b1);
      s0_info.has0       = (row_ff != '0);
      s0_info.has1       = ((11'(row_ff) + 11'd1) >= h_eff);
      s0_info.conv       = (row_ff >= ROW_BITS'(2)) && (col_ff >= CW'(2));
      s0_info.edge_value = '0;
   end

   // Pipeline valid bits and stage payloads.
   logic           s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   stage_info_type s1_info_ff, s2_info_ff, s3_info_ff, s4_info_ff;
   stage_info_type s2_info_in;
   logic [AW-1:0]  s1_idx_ff;

   // Line stores: the lower one is written on accept, the upper one while the sample is in stage one.
   logic [SAMPLE_BITS-1:0] upper_mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] lower_mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_top_ff, rd_mid_ff, rd_edge_ff;
   logic                   fwd_top;

   assign fwd_top = s1_valid_ff && (s1_idx_ff == idx);

   always_ff @(posedge clock) begin
      if (accept) begin
         lower_mem[idx] <= req_sample;
         rd_mid_ff      <= lower_mem[idx];
         rd_edge_ff     <= lower_mem[lidx];
      end
   end

   // The word being moved into the upper store is forwarded to a sample at the same slot.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         upper_mem[s1_idx_ff] <= rd_mid_ff;
      end
      if (accept) begin
         rd_top_ff <= fwd_top ? rd_mid_ff : upper_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      s2_info_in            = s1_info_ff;
      s2_info_in.edge_value = rd_edge_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= s0_info;
         s1_idx_ff  <= idx;
      end
      s2_info_ff <= s2_info_in;
      s3_info_ff <= s2_info_ff;
      s4_info_ff <= s3_info_ff;
   end

   // Kernel coefficients, taken as signed values from the low CB bits of their 16-bit slots.
   logic signed [CB-1:0] coef_w [9];
   logic [15:0]          slot_w [9];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         slot_w[n]     = coef_low_ff[16*n +: 16];
         slot_w[n + 4] = coef_mid_ff[16*n +: 16];
      end
      slot_w[8] = coef_high_ff;
      for (int n = 0; n < 9; n++) begin
         coef_w[n] = $signed(slot_w[n][CB-1:0]);
      end
   end

   // Window: three rows of three tap cells; new data enters at the right.
   cell_ctl_type           cell_ctl;
   logic [SAMPLE_BITS-1:0] row_entry [3];
   logic [SAMPLE_BITS-1:0] shift_w   [3][3];
   logic [SAMPLE_BITS-1:0] tap_sel_w [3][3];
   logic signed [PW-1:0]   prod_w    [3][3];

   assign cell_ctl.shift    = s1_valid_ff;
   assign cell_ctl.shift_ch = s1_info_ff.ch;
   assign cell_ctl.prod_ch  = s2_info_ff.ch;
   assign row_entry[0]      = rd_top_ff;
   assign row_entry[1]      = rd_mid_ff;
   assign row_entry[2]      = s1_info_ff.sample;

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         ic3_tap_cell #(
            .MAX_CHANNELS (MAX_CHANNELS),
            .COEF_W       (CB)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (cell_ctl),
            .shift_in  ((j == 2) ? row_entry[i] : shift_w[i][(j == 2) ? 2 : j + 1]),
            .shift_out (shift_w[i][j]),
            .coef      (coef_w[8 - (3*i + j)]),
            .product   (prod_w[i][j]),
            .tap_sel   (tap_sel_w[i][j])
         );
      end
   end

   // Row sums, then the total.
   logic signed [RW-1:0]   row_sum_ff [3];
   logic [SAMPLE_BITS-1:0] center_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         row_sum_ff[i] <= RW'(prod_w[i][0]) + RW'(prod_w[i][1]) + RW'(prod_w[i][2]);
      end
      center_ff <= tap_sel_w[1][1];
   end

   // Round half to even at the Q.8 point, then saturate to 0..255.
   logic signed [SW-1:0]   total;
   logic [QW-1:0]          q_round;
   logic                   round_up;
   logic [SAMPLE_BITS-1:0] conv_value;

   always_comb begin
      total    = SW'(row_sum_ff[0]) + SW'(row_sum_ff[1]) + SW'(row_sum_ff[2]);
      round_up = (total[7:0] > 8'd128) || ((total[7:0] == 8'd128) && total[8]);
      q_round  = {total[SW-1], total[SW-1:8]} + QW'(round_up);
      if (q_round[QW-1]) conv_value = '0;
      else if (|q_round[QW-2:8]) conv_value = 8'hFF;
      else conv_value = q_round[7:0];
   end

   // Build the queue entry for this sample.
   result_entry_type       push_entry;
   logic                   push;
   logic [SAMPLE_BITS-1:0] first_value;
   queue_status_type       q_status;
   logic [2:0]             in_flight;

   always_comb begin
      if (s4_info_ff.at_edge) first_value = s4_info_ff.edge_value;
      else if (s4_info_ff.conv) first_value = conv_value;
      else first_value = center_ff;
      push_entry.value1 = s4_info_ff.sample;
      push_entry.row1   = s4_info_ff.row;
      push_entry.col1   = s4_info_ff.col;
      push_entry.ch1    = s4_info_ff.ch;
      if (s4_info_ff.has0) begin
         push_entry.value0 = first_value;
         push_entry.row0   = s4_info_ff.row0;
         push_entry.col0   = s4_info_ff.col0;
         push_entry.ch0    = s4_info_ff.ch;
         push_entry.has1   = s4_info_ff.has1;
      end else begin
         push_entry.value0 = s4_info_ff.sample;
         push_entry.row0   = s4_info_ff.row;
         push_entry.col0   = s4_info_ff.col;
         push_entry.ch0    = s4_info_ff.ch;
         push_entry.has1   = 1'b0;
      end
   end

   assign push = s4_valid_ff && (s4_info_ff.has0 || s4_info_ff.has1);

   // Accept only while every sample in the pipeline has a queue entry reserved.
   assign in_flight = 3'(s1_valid_ff) + 3'(s2_valid_ff) + 3'(s3_valid_ff) + 3'(s4_valid_ff);
   assign req_ready = ((FIFO_CNT_BITS+1)'(q_status.count) + (FIFO_CNT_BITS+1)'(in_flight))
                      < (FIFO_CNT_BITS+1)'(FIFO_DEPTH);

   ic3_out_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_entry      (push_entry),
      .status          (q_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_channel (rsp_out_channel),
      .rsp_last        (rsp_last)
   );

   // The pipeline never stalls, so a sample in stage one always goes on to stage four.
   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> ##2 s4_valid_ff)
      else $error("sample lost in the convolution pipeline");

   // The reservation scheme keeps the queue from overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("result queue overflow");

   // The second word of a pair is offered right after the first is taken.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("second word of a pair missing");

endmodule

/* sv/ic3_tap_cell.sv */
// One window tap: a per-channel sample register that shifts to its neighbor, and a multiplier.
module ic3_tap_cell import ic3_pkg::*; #(
   parameter int MAX_CHANNELS = 4,
   parameter int COEF_W       = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cell_ctl_type                    ctl,
   input  logic [SAMPLE_BITS-1:0]          shift_in,
   output logic [SAMPLE_BITS-1:0]          shift_out,
   input  logic signed [COEF_W-1:0]        coef,
   output logic signed [COEF_W+SAMPLE_BITS:0] product,
   output logic [SAMPLE_BITS-1:0]          tap_sel
);

   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int PW  = COEF_W + SAMPLE_BITS + 1;

   logic [SAMPLE_BITS-1:0] tap_ff [MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0] prod_tap;
   logic signed [PW-1:0]   product_in;
   logic signed [PW-1:0]   product_ff;
   logic [SAMPLE_BITS-1:0] tap_sel_ff;

   // The neighbor takes this cell's value of the channel being shifted.
   assign shift_out = tap_ff[ctl.shift_ch[CHW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            tap_ff[k] <= '0;
         end
      end else if (ctl.shift) begin
         tap_ff[ctl.shift_ch[CHW-1:0]] <= shift_in;
      end
   end

   // Product of the selected channel's tap with this cell's coefficient.
   assign prod_tap   = tap_ff[ctl.prod_ch[CHW-1:0]];
   assign product_in = $signed({1'b0, prod_tap}) * coef;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      tap_sel_ff <= prod_tap;
   end

   assign product = product_ff;
   assign tap_sel = tap_sel_ff;

endmodule

/* sv/ic3_out_queue.sv */
// Result queue: one entry per sample, delivered as one or two words.
module ic3_out_queue import ic3_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  result_entry_type       push_entry,
   output queue_status_type       status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_pixel_value,
   output logic [ROW_BITS-1:0]    rsp_out_row,
   output logic [COL_BITS-1:0]    rsp_out_column,
   output logic [CH_BITS-1:0]     rsp_out_channel,
   output logic                   rsp_last
);

   result_entry_type         entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] head_ff, head_in;
   logic [FIFO_PTR_BITS-1:0] tail_ff, tail_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     phase_ff, phase_in;
   result_entry_type         head_entry;
   logic                     pop_word;
   logic                     pop_entry;

   // Present the first or second word of the head entry.
   assign head_entry = entry_ff[head_ff];
   assign rsp_valid  = (count_ff != '0);

   always_comb begin
      if (!phase_ff) begin
         rsp_pixel_value = head_entry.value0;
         rsp_out_row     = head_entry.row0;
         rsp_out_column  = head_entry.col0;
         rsp_out_channel = head_entry.ch0;
         rsp_last        = !head_entry.has1;
      end else begin
         rsp_pixel_value = head_entry.value1;
         rsp_out_row     = head_entry.row1;
         rsp_out_column  = head_entry.col1;
         rsp_out_channel = head_entry.ch1;
         rsp_last        = 1'b1;
      end
   end

   assign pop_word  = rsp_valid && rsp_ready;
   assign pop_entry = pop_word && rsp_last;

   // Pointer, count and word phase.
   always_comb begin
      head_in  = pop_entry ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop_entry);
      phase_in = pop_word ? !rsp_last : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_entry;
      end
   end

   assign status.count = count_ff;
   assign status.full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));

endmodule
